/* design/ams_pkg.sv */
`timescale 1ns / 1ps
package ams_pkg;

    localparam int AXIS_W      = 16;
    localparam int SUM_W       = 32;
    localparam int MAG_W       = 16;
    localparam int THRESH_W    = 16;
    localparam int INDEX_W     = 8;
    localparam int COUNT_W     = 8;
    localparam int ADDED_W     = 7;
    localparam int TOTAL_W     = 32;
    localparam int WINDOW_DEFAULT = 30;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd26000;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [MAG_W-1:0] MAG_MAX = 16'd56755;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_SQUARE,
        FRONT_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_ROOT,
        BACK_UPDATE
    } t_back_state;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } t_sum_push;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } t_sum_pop;

endpackage

/* design/ams_in_if.sv */
`timescale 1ns / 1ps
interface ams_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [ams_pkg::AXIS_W-1:0] accel_x;
    logic signed [ams_pkg::AXIS_W-1:0] accel_y;
    logic signed [ams_pkg::AXIS_W-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

/* design/ams_out_if.sv */
`timescale 1ns / 1ps
interface ams_out_if;
    logic                         valid;
    logic                         ready;
    logic [ams_pkg::MAG_W-1:0]    magnitude;
    logic                         window_end;
    logic [ams_pkg::ADDED_W-1:0]  steps_added;
    logic [ams_pkg::TOTAL_W-1:0]  step_total;

    modport source (output valid, output magnitude, output window_end,
                    output steps_added, output step_total, input ready);
    modport sink (input valid, input magnitude, input window_end,
                  input steps_added, input step_total, output ready);
endinterface

/* design/ams_cfg_if.sv */
`timescale 1ns / 1ps
interface ams_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ams_pkg::THRESH_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/accel_magnitude_step_counter.sv */
`timescale 1ns / 1ps
// Step counter on a stream of three-axis accelerometer samples.
// i_sample carries one signed sample per axis; an item is taken when valid
// and ready are both high. o_result returns one item per sample: the floor
// square root of the sum of squares, a window-end flag, the steps added at
// that window end and the running 32-bit step total.
// i_cfg writes the 16-bit peak threshold; it is always ready and should be
// written only while no sample is in flight.
// The front squares the three axes on one multiplier and hands the sum to a
// two-entry queue. The back resolves the square root one result bit per
// cycle, then updates the window state, and takes no new sum until it has
// finished the last. Sustained throughput is set by the 16-step square root.
// While the receiver stalls, the finished item is held in the output register;
// the back then waits, the queue fills, and i_sample.ready, which is low while
// the front is busy, stays low once both queue entries and the front are occupied.
// Reset clears the window state, the step total and all valid flags and
// restores the threshold to 26000.
module accel_magnitude_step_counter #(
    parameter int WINDOW = ams_pkg::WINDOW_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ams_in_if.sink    i_sample,
    ams_cfg_if.sink   i_cfg,
    ams_out_if.source o_result
);

    logic [ams_pkg::THRESH_W-1:0] r_threshold;
    ams_pkg::t_sum_push           w_push;
    logic                         w_push_ready;
    ams_pkg::t_sum_pop            w_pop;
    logic                         w_pop_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ams_pkg::THRESH_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_threshold <= i_cfg.data;
        end
    end

    ams_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (i_sample),
        .o_push       (w_push),
        .i_push_ready (w_push_ready)
    );

    ams_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .o_pop        (w_pop),
        .i_pop_ready  (w_pop_ready)
    );

    ams_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop       (w_pop),
        .o_pop_ready (w_pop_ready),
        .i_threshold (r_threshold),
        .o_result    (o_result)
    );

`ifndef SYNTHESIS
    a_added_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.window_end |-> o_result.steps_added == '0)
        else $error("steps added outside a window end");

    a_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.magnitude <= ams_pkg::MAG_MAX)
        else $error("magnitude above the largest possible root");

    a_push_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid && !w_push_ready |=> w_push.valid && $stable(w_push.sum))
        else $error("front dropped or changed a sum while the queue was full");
`endif

endmodule

/* design/ams_front.sv */
`timescale 1ns / 1ps
module ams_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ams_in_if.sink             i_sample,
    output ams_pkg::t_sum_push o_push,
    input  logic               i_push_ready
);

    ams_pkg::t_front_state r_state, n_state;
    logic [1:0]                   r_axis, n_axis;
    logic [ams_pkg::AXIS_W-1:0]   r_ax, r_ay, r_az;
    logic [ams_pkg::SUM_W-1:0]    r_acc, n_acc;
    logic [ams_pkg::AXIS_W-1:0]   w_operand;
    logic [ams_pkg::SUM_W-1:0]    w_square;
    logic                         w_accept;

    assign w_accept = i_sample.valid && i_sample.ready;

    // One shared 16x16 multiplier squares the three axes in turn.
    always_comb begin
        case (r_axis)
            2'd0:    w_operand = r_ax;
            2'd1:    w_operand = r_ay;
            default: w_operand = r_az;
        endcase
    end

    assign w_square = ams_pkg::SUM_W'(w_operand) * ams_pkg::SUM_W'(w_operand);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ams_pkg::FRONT_IDLE;
            r_axis  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    // Magnitude of each axis; the most negative code maps to 0x8000.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ax <= i_sample.accel_x[ams_pkg::AXIS_W-1] ? -i_sample.accel_x : i_sample.accel_x;
            r_ay <= i_sample.accel_y[ams_pkg::AXIS_W-1] ? -i_sample.accel_y : i_sample.accel_y;
            r_az <= i_sample.accel_z[ams_pkg::AXIS_W-1] ? -i_sample.accel_z : i_sample.accel_z;
        end
        r_acc <= n_acc;
    end

    always_comb begin
        n_state         = r_state;
        n_axis          = r_axis;
        n_acc           = r_acc;
        i_sample.ready  = 1'b0;
        o_push.valid    = 1'b0;
        o_push.sum      = r_acc;
        case (r_state)
            ams_pkg::FRONT_IDLE: begin
                i_sample.ready = 1'b1;
                if (i_sample.valid) begin
                    n_state = ams_pkg::FRONT_SQUARE;
                    n_axis  = 2'd0;
                    n_acc   = '0;
                end
            end
            ams_pkg::FRONT_SQUARE: begin
                n_acc  = r_acc + w_square;
                n_axis = r_axis + 2'd1;
                if (r_axis == 2'd2) begin
                    n_state = ams_pkg::FRONT_PUSH;
                end
            end
            ams_pkg::FRONT_PUSH: begin
                o_push.valid = 1'b1;
                if (i_push_ready) begin
                    n_state = ams_pkg::FRONT_IDLE;
                end
            end
            default: begin
                n_state = ams_pkg::FRONT_IDLE;
            end
        endcase
    end

endmodule

/* design/ams_queue.sv */
`timescale 1ns / 1ps
module ams_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ams_pkg::t_sum_push i_push,
    output logic               o_push_ready,
    output ams_pkg::t_sum_pop  o_pop,
    input  logic               i_pop_ready
);

    localparam int PTR_W = $clog2(ams_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ams_pkg::QUEUE_DEPTH + 1);

    logic [ams_pkg::SUM_W-1:0] r_data [ams_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]          r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]          r_count;
    logic                      w_push, w_pop;

    assign o_push_ready = (r_count != CNT_W'(ams_pkg::QUEUE_DEPTH));
    assign o_pop.valid  = (r_count != '0);
    assign o_pop.sum    = r_data[r_rd_ptr];
    assign w_push       = i_push.valid && o_push_ready;
    assign w_pop        = o_pop.valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(ams_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(ams_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wr_ptr] <= i_push.sum;
        end
    end

endmodule

/* design/ams_back.sv */
`timescale 1ns / 1ps
module ams_back #(
    parameter int WINDOW = ams_pkg::WINDOW_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ams_pkg::t_sum_pop            i_pop,
    output logic                         o_pop_ready,
    input  logic [ams_pkg::THRESH_W-1:0] i_threshold,
    ams_out_if.source                    o_result
);

    ams_pkg::t_back_state r_state, n_state;
    logic [ams_pkg::SUM_W-1:0]   r_rem, n_rem;
    logic [ams_pkg::SUM_W-1:0]   r_res, n_res;
    logic [ams_pkg::SUM_W-1:0]   r_bit, n_bit;
    logic [ams_pkg::SUM_W-1:0]   w_trial;

    logic [ams_pkg::INDEX_W-1:0] r_index, n_index;
    logic                        r_above, n_above;
    logic [ams_pkg::COUNT_W-1:0] r_count, n_count;
    logic [ams_pkg::TOTAL_W-1:0] r_total, n_total;

    logic                        r_out_valid, n_out_valid;
    logic [ams_pkg::MAG_W-1:0]   r_out_mag, n_out_mag;
    logic                        r_out_end, n_out_end;
    logic [ams_pkg::ADDED_W-1:0] r_out_added, n_out_added;

    logic [ams_pkg::MAG_W-1:0]   w_mag;
    logic [ams_pkg::INDEX_W-1:0] w_index_inc;
    logic                        w_out_free;

    assign w_trial     = r_res + r_bit;
    assign w_mag       = r_res[ams_pkg::MAG_W-1:0];
    assign w_index_inc = r_index + 1'b1;
    assign w_out_free  = !r_out_valid || o_result.ready;

    assign o_result.valid       = r_out_valid;
    assign o_result.magnitude   = r_out_mag;
    assign o_result.window_end  = r_out_end;
    assign o_result.steps_added = r_out_added;
    assign o_result.step_total  = r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ams_pkg::BACK_IDLE;
            r_index     <= '0;
            r_above     <= 1'b0;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_index     <= n_index;
            r_above     <= n_above;
            r_count     <= n_count;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_res       <= n_res;
        r_bit       <= n_bit;
        r_out_mag   <= n_out_mag;
        r_out_end   <= n_out_end;
        r_out_added <= n_out_added;
    end

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_res       = r_res;
        n_bit       = r_bit;
        n_index     = r_index;
        n_above     = r_above;
        n_count     = r_count;
        n_total     = r_total;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_mag   = r_out_mag;
        n_out_end   = r_out_end;
        n_out_added = r_out_added;
        o_pop_ready = 1'b0;
        case (r_state)
            ams_pkg::BACK_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop.valid) begin
                    n_rem   = i_pop.sum;
                    n_res   = '0;
                    n_bit   = ams_pkg::SUM_W'(1) << (ams_pkg::SUM_W - 2);
                    n_state = ams_pkg::BACK_ROOT;
                end
            end
            ams_pkg::BACK_ROOT: begin
                // One result bit per cycle of the restoring square root.
                if (r_rem >= w_trial) begin
                    n_rem = r_rem - w_trial;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_state = ams_pkg::BACK_UPDATE;
                end
            end
            ams_pkg::BACK_UPDATE: begin
                if (w_out_free) begin
                    n_out_mag   = w_mag;
                    n_out_end   = 1'b0;
                    n_out_added = '0;
                    n_out_valid = 1'b1;
                    if (w_mag > i_threshold && !r_above) begin
                        n_above = 1'b1;
                        if (r_count != '1) begin
                            n_count = r_count + 1'b1;
                        end
                    end else if (w_mag < i_threshold && r_above) begin
                        n_above = 1'b0;
                    end
                    n_index = w_index_inc;
                    // The sample that fills the window closes it, its own crossing included.
                    if (w_index_inc >= ams_pkg::INDEX_W'(WINDOW) || w_index_inc == '0) begin
                        n_out_added = n_count[ams_pkg::COUNT_W-1:1];
                        n_out_end   = 1'b1;
                        n_total     = r_total + ams_pkg::TOTAL_W'(n_count[ams_pkg::COUNT_W-1:1]);
                        n_index     = '0;
                        n_above     = 1'b0;
                        n_count     = '0;
                    end
                    n_state = ams_pkg::BACK_IDLE;
                end
            end
            default: begin
                n_state = ams_pkg::BACK_IDLE;
            end
        endcase
    end

endmodule
